>>> rtl/wmm_pkg.sv
package wmm_pkg;

  localparam int unsigned PowerW = 19;
  localparam int unsigned TimeW = 32;
  localparam int unsigned AxisW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 64;

  localparam logic [TimeW-1:0] MaxAgeReset = 32'd120000;

  localparam logic signed [PowerW-1:0] PowerMax = {1'b0, {(PowerW-1){1'b1}}};
  localparam logic signed [PowerW-1:0] PowerMin = {1'b1, {(PowerW-1){1'b0}}};

  // A multiple of 500 that makes any sample non-negative before the divide.
  localparam logic [19:0] DivOffset = 20'd262500;
  localparam logic [19:0] CeilBias = 20'd499;
  localparam logic signed [15:0] OffsetQuot = 16'sd525;
  // Reciprocals: x / 125 = (x * 268436) >> 25 and x / 5 = (x * 209716) >> 20,
  // both exact for 18-bit x.
  localparam logic [18:0] Recip125 = 19'd268436;
  localparam logic [17:0] Recip5 = 18'd209716;
  localparam logic signed [15:0] StepW = 16'sd50;

  typedef struct packed {
    logic valid;
    logic signed [PowerW-1:0] value;
    logic [TimeW-1:0] stamp;
  } cell_t;

endpackage

>>> rtl/wmm_cell.sv
module wmm_cell
  import wmm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  cell_t din,
  output cell_t dout
);

  cell_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held.value <= din.value;
      held.stamp <= din.stamp;
    end
    if (rst) begin
      held.valid <= 1'b0;
    end else if (shift) begin
      held.valid <= din.valid;
    end
  end

  assign dout = held;

endmodule

>>> rtl/wmm_scan.sv
module wmm_scan
  import wmm_pkg::*;
(
  input  logic                     clk,
  input  logic                     start,
  input  logic                     step,
  input  cell_t                    tail,
  input  logic [TimeW-1:0]         now,
  input  logic [TimeW-1:0]         max_age,
  output logic                     keep,
  output logic signed [PowerW-1:0] lo,
  output logic signed [PowerW-1:0] hi,
  output logic [CountW-1:0]        kept,
  output logic [CountW-1:0]        dropped
);

  logic             dropping;
  logic [TimeW-1:0] age;
  logic             too_old;
  logic             drop;

  assign age = now - tail.stamp;
  assign too_old = age > max_age;
  assign drop = tail.valid && dropping && too_old;
  assign keep = tail.valid && !drop;

  always_ff @(posedge clk) begin
    if (start) begin
      dropping <= 1'b1;
      lo <= PowerMax;
      hi <= PowerMin;
      kept <= '0;
      dropped <= '0;
    end else if (step) begin
      if (keep) begin
        dropping <= 1'b0;
        kept <= kept + 1'b1;
        if (tail.value < lo) begin
          lo <= tail.value;
        end
        if (tail.value > hi) begin
          hi <= tail.value;
        end
      end
      if (drop) begin
        dropped <= dropped + 1'b1;
      end
    end
  end

endmodule

>>> rtl/wmm_scale.sv
module wmm_scale
  import wmm_pkg::*;
(
  input  logic                     clk,
  input  logic signed [PowerW-1:0] lo,
  input  logic signed [PowerW-1:0] hi,
  input  logic signed [PowerW-1:0] newest,
  output logic signed [AxisW-1:0]  low_w,
  output logic signed [AxisW-1:0]  high_w,
  output logic signed [AxisW-1:0]  newest_w
);

  logic [19:0] u_lo, u_hi;
  logic [PowerW-1:0] mag;
  logic [17:0] y_lo, y_hi, y_new;
  logic neg;
  logic [36:0] p_lo, p_hi;
  logic [35:0] p_new;
  logic [11:0] q_lo, q_hi;
  logic [14:0] q_new;
  logic neg2;
  logic signed [15:0] lo_q, hi_q;
  logic signed [AxisW-1:0] high_raw;

  assign u_lo = 20'(21'(signed'(lo)) + 21'(DivOffset));
  assign u_hi = 20'(21'(signed'(hi)) + 21'(DivOffset) + 21'(CeilBias));
  assign mag = newest[PowerW-1] ? PowerW'(-newest) : PowerW'(newest);

  always_ff @(posedge clk) begin
    y_lo <= u_lo[19:2];
    y_hi <= u_hi[19:2];
    y_new <= mag[18:1];
    neg <= newest[PowerW-1];
  end

  assign p_lo = 37'(y_lo) * 37'(Recip125);
  assign p_hi = 37'(y_hi) * 37'(Recip125);
  assign p_new = 36'(y_new) * 36'(Recip5);

  always_ff @(posedge clk) begin
    q_lo <= p_lo[36:25];
    q_hi <= p_hi[36:25];
    q_new <= p_new[34:20];
    neg2 <= neg;
  end

  assign lo_q = $signed({4'b0, q_lo}) - OffsetQuot;
  assign hi_q = $signed({4'b0, q_hi}) - OffsetQuot;
  assign low_w = 16'(lo_q * StepW);
  assign high_raw = 16'(hi_q * StepW);
  assign high_w = (high_raw == low_w) ? 16'(low_w + StepW) : high_raw;
  assign newest_w = neg2 ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});

endmodule

>>> rtl/windowed_min_max_autorange.sv
// Channel  Direction  Fields (lowest bits first)
// s_axis   in         power_tenths_w[18:0], sample_time_ms[50:19], zero pad to 56
// m_axis   out        axis_low_w, axis_high_w, newest_w, kept_count, dropped_count
// cfg      in         max_age_ms[31:0], written whenever cfg_wen is high
//
// Each transaction shifts the new sample into the cell chain, rotates the whole
// chain once past the age and min/max step at its tail (SCAN), and then passes
// through the autorange pipeline in FIN1, FIN2 and DONE.
// rst is synchronous and clears all valid bits; max_age_ms returns to 120000.
// A new sample is taken while the previous result still waits on m_tready.
module windowed_min_max_autorange
  import wmm_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,  // power_tenths_w, sample_time_ms
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,  // low, high, newest, kept, dropped
  input  logic                cfg_wen,
  input  logic [TimeW-1:0]    cfg_wdata
);

  localparam int CntW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    FIN1,
    FIN2,
    DONE
  } state_t;

  state_t state;
  logic [CntW-1:0] cnt;
  logic [TimeW-1:0] max_age;
  logic [TimeW-1:0] now;
  logic signed [PowerW-1:0] newest;
  logic accept;
  logic shift;
  logic keep;
  cell_t head;
  cell_t chain [BUFFER_DEPTH];
  logic signed [PowerW-1:0] lo, hi;
  logic [CountW-1:0] kept, dropped;
  logic signed [AxisW-1:0] low_w, high_w, newest_w;

  assign s_tready = (state == IDLE);
  assign accept = s_tvalid && s_tready;
  assign shift = accept || (state == SCAN);

  always_comb begin
    if (accept) begin
      head.valid = 1'b1;
      head.value = s_tdata[PowerW-1:0];
      head.stamp = s_tdata[PowerW+TimeW-1:PowerW];
    end else begin
      head.valid = keep;
      head.value = chain[BUFFER_DEPTH-1].value;
      head.stamp = chain[BUFFER_DEPTH-1].stamp;
    end
  end

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      wmm_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .din(head), .dout(chain[i]));
    end else begin : g_body
      wmm_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .din(chain[i-1]),
                       .dout(chain[i]));
    end
  end

  wmm_scan u_scan (
    .clk(clk),
    .start(accept),
    .step(state == SCAN),
    .tail(chain[BUFFER_DEPTH-1]),
    .now(now),
    .max_age(max_age),
    .keep(keep),
    .lo(lo),
    .hi(hi),
    .kept(kept),
    .dropped(dropped)
  );

  wmm_scale u_scale (
    .clk(clk),
    .lo(lo),
    .hi(hi),
    .newest(newest),
    .low_w(low_w),
    .high_w(high_w),
    .newest_w(newest_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= MaxAgeReset;
    end else if (cfg_wen) begin
      max_age <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now <= s_tdata[PowerW+TimeW-1:PowerW];
      newest <= s_tdata[PowerW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            cnt <= '0;
            state <= SCAN;
          end
        end
        SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(BUFFER_DEPTH - 1)) begin
            state <= FIN1;
          end
        end
        FIN1: state <= FIN2;
        FIN2: state <= DONE;
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {dropped, kept, newest_w, high_w, low_w};
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> rtl/wmm_checker.sv
module wmm_checker
  import wmm_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  a_span_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[31:16]) > $signed(m_tdata[15:0]))
    else $error("axis high is not above axis low");

  a_kept_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[55:48] != 8'd0 || BUFFER_DEPTH > 255))
    else $error("result reports an empty window");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind windowed_min_max_autorange wmm_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_wmm_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

>>> tb/sv/windowed_min_max_autorange_test.sv
`timescale 1ns / 1ps

module windowed_min_max_autorange_test;
  import wmm_pkg::*;

  localparam int Depth = 128;
  localparam int AxisStep = 50;
  localparam int HoldCycles = 1500;

  typedef struct packed {
    logic signed [AxisW-1:0] axis_low;
    logic signed [AxisW-1:0] axis_high;
    logic signed [AxisW-1:0] newest;
    logic [CountW-1:0] kept;
    logic [CountW-1:0] dropped;
  } readout_t;

  typedef struct packed {
    logic signed [PowerW-1:0] power;
    logic [TimeW-1:0] stamp;
    logic typed;
    readout_t known;
  } sample_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [InDataW-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic cfg_wen;
  logic [TimeW-1:0] cfg_wdata;

  int win_values [Depth];
  logic [TimeW-1:0] win_stamps [Depth];
  int win_head;
  int win_fill;
  logic [TimeW-1:0] age_limit;

  readout_t pending_readouts[$];
  int failures;
  int samples_sent;
  int readouts_checked;
  int limits_used;
  int peak_kept;
  int total_aged;
  bit sender_calm;
  logic [TimeW-1:0] last_stamp;

  windowed_min_max_autorange #(
    .BUFFER_DEPTH(Depth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("windowed_min_max_autorange regression: fail");
    $finish;
  end

  task automatic predict_window(input logic signed [PowerW-1:0] power,
                                input logic [TimeW-1:0] stamp, output readout_t res);
    int val;
    int lo;
    int hi;
    int q_lo;
    int q_hi;
    int k;
    int aged;
    bit scanning;
    logic [TimeW-1:0] age;
    val = power;
    aged = 0;
    if (win_fill >= Depth) begin
      win_head = (win_head + 1) % Depth;
      win_fill = Depth - 1;
    end
    win_values[(win_head + win_fill) % Depth] = val;
    win_stamps[(win_head + win_fill) % Depth] = stamp;
    win_fill++;
    scanning = 1'b1;
    while (win_fill > 0 && scanning) begin
      age = stamp - win_stamps[win_head];
      if (age > age_limit) begin
        win_head = (win_head + 1) % Depth;
        win_fill--;
        aged++;
      end else begin
        scanning = 1'b0;
      end
    end
    lo = win_values[win_head];
    hi = lo;
    for (k = 1; k < win_fill; k++) begin
      if (win_values[(win_head + k) % Depth] < lo) lo = win_values[(win_head + k) % Depth];
      if (win_values[(win_head + k) % Depth] > hi) hi = win_values[(win_head + k) % Depth];
    end
    q_lo = lo / 500;
    if (lo % 500 != 0 && lo < 0) q_lo--;
    q_hi = hi / 500;
    if (hi % 500 != 0 && hi > 0) q_hi++;
    q_lo = q_lo * AxisStep;
    q_hi = q_hi * AxisStep;
    if (q_hi - q_lo < AxisStep) q_hi = q_lo + AxisStep;
    res.axis_low = q_lo[AxisW-1:0];
    res.axis_high = q_hi[AxisW-1:0];
    res.newest = 16'(val / 10);
    res.kept = win_fill[CountW-1:0];
    res.dropped = aged[CountW-1:0];
    if (win_fill > peak_kept) peak_kept = win_fill;
    total_aged += aged;
  endtask

  function automatic int sender_gap();
    int r;
    r = $urandom_range(99);
    if (sender_calm || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(20, 4);
    return $urandom_range(300, 50);
  endfunction

  function automatic logic signed [PowerW-1:0] random_power();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 8) v = $urandom_range(1) ? 200000 : -200000;
    else if (r < 30) v = (int'($urandom_range(798)) - 399) * 500 + int'($urandom_range(2)) - 1;
    else v = int'($urandom_range(400000)) - 200000;
    return v[PowerW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] random_step(input int typ);
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(2 * typ);
    if (r < 80) return '0;
    if (r < 88) return -(int'($urandom_range(3 * typ, 1)));
    if (r < 95) return $urandom_range(40 * typ, 2 * typ);
    return $urandom;
  endfunction

  task automatic send_sample(input logic signed [PowerW-1:0] power,
                             input logic [TimeW-1:0] stamp, input logic typed,
                             input readout_t known);
    int gap;
    readout_t res;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(InDataW - TimeW - PowerW){1'b0}}, stamp, power};
    do @(posedge clk); while (!s_tready);
    predict_window(power, stamp, res);
    pending_readouts.push_back(typed ? known : res);
    samples_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic set_age_limit(input logic [TimeW-1:0] limit);
    drain_results();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_wen <= 1'b0;
    age_limit = limit;
    limits_used++;
  endtask

  task automatic run_phase(input int count, input logic [TimeW-1:0] limit, input int typ,
                           input bit calm, input logic [TimeW-1:0] start);
    int n;
    set_age_limit(limit);
    sender_calm = calm;
    last_stamp = start;
    for (n = 0; n < count; n++) begin
      last_stamp = last_stamp + random_step(typ);
      send_sample(random_power(), last_stamp, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    readout_t want;
    readout_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.axis_low = m_tdata[15:0];
      got.axis_high = m_tdata[31:16];
      got.newest = m_tdata[47:32];
      got.kept = m_tdata[55:48];
      got.dropped = m_tdata[63:56];
      if (pending_readouts.size() == 0) begin
        $error("unexpected result transaction: m_tdata %h", m_tdata);
        failures++;
      end else begin
        want = pending_readouts.pop_front();
        readouts_checked++;
        if (got.axis_low !== want.axis_low) begin
          $error("axis_low_w: expected %0d, got %0d", want.axis_low, got.axis_low);
          failures++;
        end
        if (got.axis_high !== want.axis_high) begin
          $error("axis_high_w: expected %0d, got %0d", want.axis_high, got.axis_high);
          failures++;
        end
        if (got.newest !== want.newest) begin
          $error("newest_w: expected %0d, got %0d", want.newest, got.newest);
          failures++;
        end
        if (got.kept !== want.kept) begin
          $error("kept_count: expected %0d, got %0d", want.kept, got.kept);
          failures++;
        end
        if (got.dropped !== want.dropped) begin
          $error("dropped_count: expected %0d, got %0d", want.dropped, got.dropped);
          failures++;
        end
      end
    end
  end

  initial begin
    int stall_left;
    int since_switch;
    bit calm;
    bit held;
    stall_left = 0;
    since_switch = 0;
    calm = 1'b0;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      // One long hold-off lets the block fill up and push back on its input.
      if (!held && readouts_checked >= 400) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      since_switch++;
      if (since_switch >= 3000) begin
        since_switch = 0;
        calm = ($urandom_range(2) == 0);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 25) begin
        stall_left = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(200, 20);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    sample_row_t directed_rows [21];
    int n;
    directed_rows = '{
      '{19'sd0,       32'd1000,       1'b1, '{16'sd0, 16'sd50, 16'sd0, 8'd1, 8'd0}},
      '{19'sd200000,  32'd201000,     1'b1, '{16'sd20000, 16'sd20050, 16'sd20000, 8'd1, 8'd1}},
      '{-19'sd200000, 32'd401000,     1'b1, '{-16'sd20000, -16'sd19950, -16'sd20000, 8'd1, 8'd1}},
      '{-19'sd200000, 32'd401000,     1'b1, '{-16'sd20000, -16'sd19950, -16'sd20000, 8'd2, 8'd0}},
      '{19'sd1,       32'd402000,     1'b0, '0},
      '{-19'sd1,      32'd403000,     1'b0, '0},
      '{19'sd499,     32'd404000,     1'b0, '0},
      '{19'sd500,     32'd405000,     1'b0, '0},
      '{19'sd501,     32'd406000,     1'b0, '0},
      '{-19'sd499,    32'd407000,     1'b0, '0},
      '{-19'sd500,    32'd408000,     1'b0, '0},
      '{-19'sd501,    32'd409000,     1'b0, '0},
      '{19'sd9,       32'd410000,     1'b0, '0},
      '{-19'sd19,     32'd411000,     1'b0, '0},
      '{19'sd123456,  32'd522000,     1'b0, '0},
      '{-19'sd77777,  32'd521999,     1'b0, '0},
      '{19'sd5,       32'd100,        1'b0, '0},
      '{19'sd200000,  32'hFFFF_FFFF,  1'b1, '{16'sd20000, 16'sd20050, 16'sd20000, 8'd1, 8'd1}},
      '{-19'sd123,    32'd0,          1'b0, '0},
      '{19'sd199999,  32'd1,          1'b0, '0},
      '{-19'sd199999, 32'd2,          1'b0, '0}
    };
    failures = 0;
    samples_sent = 0;
    readouts_checked = 0;
    limits_used = 0;
    peak_kept = 0;
    total_aged = 0;
    sender_calm = 1'b0;
    win_head = 0;
    win_fill = 0;
    age_limit = MaxAgeReset;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < 21; n++) begin
      send_sample(directed_rows[n].power, directed_rows[n].stamp, directed_rows[n].typed,
                  directed_rows[n].known);
    end

    run_phase(200, 32'hFFFF_FFFF, 1000, 1'b0, $urandom);
    run_phase(100, 32'd0, 2, 1'b0, $urandom);
    run_phase(200, 32'd5000, 1000, 1'b1, $urandom);
    run_phase(150, $urandom_range(300000, 20000), 1000, 1'b0, 32'hFFFF_0000);
    run_phase(100, 32'd1, 1, 1'b0, $urandom);

    drain_results();
    repeat (Depth + 8) @(posedge clk);
    $display("Checked %0d results from %0d samples under %0d age limits and the reset limit.",
             readouts_checked, samples_sent, limits_used);
    $display("The window held up to %0d samples, and %0d samples aged out in total.",
             peak_kept, total_aged);
    if (failures == 0) begin
      $display("windowed_min_max_autorange regression: pass");
    end else begin
      $display("windowed_min_max_autorange regression: fail");
    end
    $finish;
  end

endmodule
